/* rtl/core/serial_dual_ring_buffer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the serial dual ring buffer
// Shared concurrent check forms; each use names its own label and clock.
// ----------------------------------------------------------------------------
`ifndef SERIAL_DUAL_RING_BUFFER_MACROS_SVH
`define SERIAL_DUAL_RING_BUFFER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SDRB_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdrb check failed");

// Next-cycle implication, disabled during reset
`define SDRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdrb next-cycle check failed");

`endif

/* rtl/core/sdrb_pkg.sv */
// ----------------------------------------------------------------------------
// sdrb_pkg
// Types and constants shared by the serial dual ring buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdrb_pkg;

  // default number of slots in each ring
  localparam int RING_DEPTH_DEF = 256;

  // entries in the command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_HOST_WRITE = 2'd0,
    OP_HOST_READ  = 2'd1,
    OP_LINE_RX    = 2'd2,
    OP_TX_DRAIN   = 2'd3
  } opcode_t;

  // classified command, one class bit set
  typedef struct packed {
    logic       is_write;
    logic       is_read;
    logic       is_rx;
    logic       is_drain;
    logic [7:0] data;
    logic       line_ready;
    logic       last;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/sdrb_ifs.sv */
// ----------------------------------------------------------------------------
// sdrb channel interfaces
// Valid/ready channels for the event words and the result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic       line_tx_ready;
  logic       burst_end;

  modport source (output valid, opcode, data_byte, line_tx_ready, burst_end,
                  input ready);
  modport sink   (input valid, opcode, data_byte, line_tx_ready, burst_end,
                  output ready);
endinterface

interface sdrb_out_if;
  logic       valid;
  logic       ready;
  logic       line_tx_valid;
  logic [7:0] line_tx_byte;
  logic       accepted;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [7:0] rx_occupancy;

  modport source (output valid, line_tx_valid, line_tx_byte, accepted, read_valid,
                  read_byte, rx_occupancy, input ready);
  modport sink   (input valid, line_tx_valid, line_tx_byte, accepted, read_valid,
                  read_byte, rx_occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/core/sdrb_front.sv */
// ----------------------------------------------------------------------------
// sdrb_front
// Accepts event words and classifies them into commands for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sdrb_front
  import sdrb_pkg::*;
(
  sdrb_in_if.sink req,
  input  logic    q_full,
  output logic    push,
  output cmd_t    cmd
);

  opcode_t op;

  // take a word whenever the queue has room
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;
  assign op        = opcode_t'(req.opcode);

  // decode the opcode into one class bit
  always_comb begin
    cmd            = '0;
    cmd.data       = req.data_byte;
    cmd.line_ready = req.line_tx_ready;
    cmd.last       = req.burst_end;
    unique case (op)
      OP_HOST_WRITE: cmd.is_write = 1'b1;
      OP_HOST_READ:  cmd.is_read  = 1'b1;
      OP_LINE_RX:    cmd.is_rx    = 1'b1;
      OP_TX_DRAIN:   cmd.is_drain = 1'b1;
      default:       cmd.is_drain = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/sdrb_queue.sv */
// ----------------------------------------------------------------------------
// sdrb_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_dual_ring_buffer_macros.svh"

module sdrb_queue
  import sdrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd,
  input  logic pop
);

  localparam logic [QUEUE_PW-1:0] QLAST = QUEUE_PW'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_PW:0]   QCAP  = (QUEUE_PW + 1)'(QUEUE_DEPTH);

  cmd_t                entry [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_PW:0]   count;

  assign full    = (count == QCAP);
  assign q_valid = (count != '0);
  assign q_cmd   = entry[rd_ptr];

  // hold queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QLAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QLAST) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

  `SDRB_ASSERT(a_q_no_overflow, clk, rst, push, !full)
  `SDRB_ASSERT(a_q_no_underflow, clk, rst, pop, q_valid)
  `SDRB_ASSERT(a_q_count_range, clk, rst, 1'b1, count <= QCAP)

endmodule

`default_nettype wire

/* rtl/core/sdrb_back.sv */
// ----------------------------------------------------------------------------
// sdrb_back
// Executes rx and tx ring commands, one per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "serial_dual_ring_buffer_macros.svh"

module sdrb_back
  import sdrb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        pop,
  sdrb_out_if.source  rsp
);

  localparam int            PW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int            CW   = (PW + 1 > 8) ? PW + 1 : 8;
  localparam logic [PW-1:0] LAST = PW'(RING_DEPTH - 1);
  localparam logic [PW:0]   DEPW = (PW + 1)'(RING_DEPTH);

  // result waiting for the memory read data
  typedef struct packed {
    logic       txv;
    logic       tx_mem;
    logic [7:0] txb;
    logic       acc;
    logic       rdv;
    logic [7:0] occ;
  } pend_t;

  logic [7:0]    rx_store [RING_DEPTH];
  logic [7:0]    tx_store [RING_DEPTH];
  logic [PW-1:0] rx_head, rx_tail, tx_head, tx_tail;
  logic [PW-1:0] rx_head_next, rx_tail_next, tx_head_next, tx_tail_next;
  logic          dropping_rest, dropping_rest_next;
  logic [7:0]    tx_rd, rx_rd;
  logic          tx_we, rx_we;
  pend_t         pend, pend_next;
  logic          pend_valid, pend_move;
  logic          out_valid;
  logic          out_txv, out_acc, out_rdv;
  logic [7:0]    out_txb, out_rdb, out_occ;
  logic          tx_empty, tx_full, still_full;
  logic [PW:0]   cnt;
  logic [CW-1:0] cnt_w;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  // move the pending result into the output word when it is free
  assign pend_move = pend_valid && (!out_valid || rsp.ready);
  assign pop       = q_valid && (!pend_valid || pend_move);

  assign tx_empty = (tx_head == tx_tail);
  assign tx_full  = (ring_next(tx_tail) == tx_head);

  // decide the command from the current pointers
  always_comb begin
    rx_head_next       = rx_head;
    rx_tail_next       = rx_tail;
    tx_head_next       = tx_head;
    tx_tail_next       = tx_tail;
    dropping_rest_next = dropping_rest;
    tx_we              = 1'b0;
    rx_we              = 1'b0;
    still_full         = 1'b0;
    pend_next          = '0;
    priority if (q_cmd.is_write) begin
      priority if (dropping_rest) begin
        pend_next.acc = 1'b0;
      end else if (tx_empty && q_cmd.line_ready) begin
        pend_next.txv = 1'b1;
        pend_next.txb = q_cmd.data;
        pend_next.acc = 1'b1;
      end else begin
        // send the head byte first to free a slot
        if (tx_full && q_cmd.line_ready) begin
          pend_next.txv    = 1'b1;
          pend_next.tx_mem = 1'b1;
          tx_head_next     = ring_next(tx_head);
        end
        still_full = tx_full && !q_cmd.line_ready;
        if (still_full) begin
          dropping_rest_next = 1'b1;
        end else begin
          tx_we         = 1'b1;
          tx_tail_next  = ring_next(tx_tail);
          pend_next.acc = 1'b1;
        end
      end
      if (q_cmd.last) begin
        dropping_rest_next = 1'b0;
      end
    end else if (q_cmd.is_read) begin
      if (rx_head != rx_tail) begin
        pend_next.rdv = 1'b1;
        rx_head_next  = ring_next(rx_head);
      end
    end else if (q_cmd.is_rx) begin
      if (ring_next(rx_tail) != rx_head) begin
        rx_we         = 1'b1;
        rx_tail_next  = ring_next(rx_tail);
        pend_next.acc = 1'b1;
      end
    end else begin
      if (!tx_empty && q_cmd.line_ready) begin
        pend_next.txv    = 1'b1;
        pend_next.tx_mem = 1'b1;
        tx_head_next     = ring_next(tx_head);
      end
    end

    // receive occupancy after the step, saturated to a byte
    if (rx_tail_next >= rx_head_next) begin
      cnt = {1'b0, rx_tail_next} - {1'b0, rx_head_next};
    end else begin
      cnt = DEPW - {1'b0, rx_head_next} + {1'b0, rx_tail_next};
    end
    cnt_w         = CW'(cnt);
    pend_next.occ = (cnt_w > CW'(255)) ? 8'hFF : cnt_w[7:0];
  end

  // ring stores: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (pop && tx_we) begin
      tx_store[tx_tail] <= q_cmd.data;
    end
    if (pop && rx_we) begin
      rx_store[rx_tail] <= q_cmd.data;
    end
    if (pop) begin
      tx_rd <= tx_store[tx_head];
      rx_rd <= rx_store[rx_head];
    end
  end

  // ring pointers and burst drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head       <= '0;
      rx_tail       <= '0;
      tx_head       <= '0;
      tx_tail       <= '0;
      dropping_rest <= 1'b0;
    end else if (pop) begin
      rx_head       <= rx_head_next;
      rx_tail       <= rx_tail_next;
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
      dropping_rest <= dropping_rest_next;
    end
  end

  // pending result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pop) begin
      pend_valid <= 1'b1;
    end else if (pend_move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pend <= pend_next;
    end
  end

  // output word, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pend_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_move) begin
      out_txv <= pend.txv;
      out_txb <= pend.tx_mem ? tx_rd : pend.txb;
      out_acc <= pend.acc;
      out_rdv <= pend.rdv;
      out_rdb <= pend.rdv ? rx_rd : 8'h00;
      out_occ <= pend.occ;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.line_tx_valid = out_txv;
  assign rsp.line_tx_byte  = out_txb;
  assign rsp.accepted      = out_acc;
  assign rsp.read_valid    = out_rdv;
  assign rsp.read_byte     = out_rdb;
  assign rsp.rx_occupancy  = out_occ;

  `SDRB_ASSERT(a_tx_ptr_range, clk, rst, 1'b1, (tx_head <= LAST) && (tx_tail <= LAST))
  `SDRB_ASSERT(a_rx_ptr_range, clk, rst, 1'b1, (rx_head <= LAST) && (rx_tail <= LAST))
  `SDRB_ASSERT(a_mem_src_sends, clk, rst, pend_valid && pend.tx_mem, pend.txv)
  `SDRB_ASSERT_NEXT(a_pop_fills_pend, clk, rst, pop, pend_valid)
  `SDRB_ASSERT(a_read_sends_nothing, clk, rst, out_valid && out_rdv,
               !out_txv && !out_acc)

endmodule

`default_nettype wire

/* rtl/core/serial_dual_ring_buffer.sv */
// ----------------------------------------------------------------------------
// serial_dual_ring_buffer
// Receive and transmit byte rings between a host and a serial line.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one event word: host write, host read, line byte received
//   or transmit drain, with the data byte, the transmitter ready flag and
//   the end-of-burst flag. rsp returns exactly one result word per event:
//   the byte sent to the line, whether a write or received byte was taken,
//   the byte read by the host and the receive occupancy after the event.
//   Each ring holds RING_DEPTH-1 bytes.
//   A word accepted into the queue executes when the back pops it, with
//   its store read and result registered in the pending stage; it then
//   moves to the output word, where rsp takes it.
//   Throughput: one word per cycle while rsp is not stalled; the back executes
//   one command a cycle with single-port ring reads at the head pointers.
//   Reset clears pointers, the burst drop flag, the queue and all valid
//   flags; ring contents are not cleared and no clearing pass is needed.
//   When the receiver stalls rsp holds its word, one further result waits
//   in the pending stage, then the two-entry queue fills and req.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_dual_ring_buffer
  import sdrb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  sdrb_in_if.sink    req,
  sdrb_out_if.source rsp
);

  logic push, q_full, q_valid, pop;
  cmd_t push_cmd, q_cmd;

  sdrb_front u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  sdrb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  sdrb_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
